>>> rtl/core/dfm_pkg.sv
`default_nettype none
package dfm_pkg;

  localparam int STATE_W = 7;
  localparam int TOKEN_W = 8;
  localparam int TOKENS = 256;

  typedef logic signed [STATE_W-1:0] state_t;
  typedef logic [TOKEN_W-1:0] token_t;

  typedef enum logic [1:0] {
    FUNC_WR_EXPLICIT = 2'd0,
    FUNC_WR_DEFAULT  = 2'd1,
    FUNC_SET_STATE   = 2'd2,
    FUNC_STEP        = 2'd3
  } func_t;

  typedef struct packed {
    logic   valid;
    state_t target;
  } entry_t;

  localparam state_t INIT_STATE = 7'sd0;
  localparam state_t HIT_STATE  = -7'sd1;
  localparam state_t DEAD_STATE = -7'sd2;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

endpackage
`default_nettype wire

>>> rtl/core/dfm_ram.sv
`default_nettype none
module dfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/dfm_outq.sv
`default_nettype none
module dfm_outq (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  input  wire dfm_pkg::state_t                     push_state,
  output logic      [dfm_pkg::OUTQ_CNT_W-1:0]      count,
  output logic                                     rsp_valid,
  input  wire logic                                rsp_ready,
  output dfm_pkg::state_t                          state_now,
  output logic                                     accepted,
  output logic                                     rejected
);

  dfm_pkg::state_t                   entries [dfm_pkg::OUTQ_DEPTH];
  logic [dfm_pkg::OUTQ_PTR_W-1:0]    wr_ptr;
  logic [dfm_pkg::OUTQ_PTR_W-1:0]    rd_ptr;
  logic                              pop;

  assign rsp_valid = (count != '0);
  assign pop       = rsp_valid & rsp_ready;
  assign state_now = entries[rd_ptr];
  assign accepted  = (state_now == dfm_pkg::HIT_STATE);
  assign rejected  = (state_now == dfm_pkg::DEAD_STATE);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_state;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + dfm_pkg::OUTQ_CNT_W'(push) - dfm_pkg::OUTQ_CNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/table_driven_dfa_matcher.sv
`default_nettype none
// Loadable byte-driven DFA. One request per cycle of any kind, tokens included, while the
// result queue has room: the explicit and default tables are read in the cycle a token is
// taken, and the registered read data selects the next state and steers the address of the
// following token in the same cycle. Each result is registered, then goes through a
// four-entry result queue. After reset a clearing pass over all (STATE_COUNT+2)*256 entries
// (16896 at the default) wipes both tables; no request is taken until it ends.
module table_driven_dfa_matcher #(
  parameter int STATE_COUNT = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire logic [1:0]       func,
  input  wire dfm_pkg::state_t  source_state,
  input  wire dfm_pkg::token_t  token,
  input  wire dfm_pkg::state_t  target_state,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output dfm_pkg::state_t       state_now,
  output logic                  accepted,
  output logic                  rejected
);

  localparam int ROWS   = STATE_COUNT + 2;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = ROW_W + dfm_pkg::TOKEN_W;
  localparam int EXP_DEPTH = ROWS * dfm_pkg::TOKENS;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(EXP_DEPTH - 1);

  function automatic logic row_valid(input dfm_pkg::state_t s);
    logic signed [7:0] r8;
    r8 = 8'(s) + 8'sd2;
    return !r8[7] && (32'(r8[6:0]) < ROWS);
  endfunction

  function automatic logic [ROW_W-1:0] row_index(input dfm_pkg::state_t s);
    logic signed [7:0] r8;
    logic [31:0]       r32;
    r8  = 8'(s) + 8'sd2;
    r32 = 32'(r8[6:0]);
    return r32[ROW_W-1:0];
  endfunction

  logic                              accept;
  dfm_pkg::func_t                    fn;
  dfm_pkg::state_t                   cur_state;
  dfm_pkg::state_t                   state_eff;
  logic                              pend;
  logic                              p_valid;
  logic                              clr_active;
  logic [ADDR_W-1:0]                 clr_idx;
  logic [dfm_pkg::OUTQ_CNT_W-1:0]    q_count;
  logic                              src_ok;
  logic                              eff_ok;

  logic                              exp_we;
  logic [ADDR_W-1:0]                 exp_waddr;
  dfm_pkg::entry_t                   exp_wdata;
  logic                              exp_re;
  logic [ADDR_W-1:0]                 exp_raddr;
  logic [dfm_pkg::STATE_W:0]         exp_rdata;
  dfm_pkg::entry_t                   exp_rd;

  logic                              def_we;
  logic [ROW_W-1:0]                  def_waddr;
  dfm_pkg::state_t                   def_wdata;
  logic [ROW_W-1:0]                  def_raddr;
  dfm_pkg::state_t                   def_rdata;

  assign fn     = dfm_pkg::func_t'(func);
  assign accept = req_valid & req_ready;
  assign src_ok = row_valid(source_state);
  assign exp_rd = dfm_pkg::entry_t'(exp_rdata);

  always_comb begin
    if (pend) begin
      state_eff = exp_rd.valid ? exp_rd.target : def_rdata;
    end else begin
      state_eff = cur_state;
    end
  end

  assign eff_ok = row_valid(state_eff);

  assign req_ready = !rst && !clr_active &&
                     ((q_count + dfm_pkg::OUTQ_CNT_W'(p_valid)) <
                      dfm_pkg::OUTQ_CNT_W'(dfm_pkg::OUTQ_DEPTH));

  always_comb begin
    exp_we    = 1'b0;
    exp_waddr = {row_index(source_state), token};
    exp_wdata = '{valid: 1'b1, target: target_state};
    def_we    = 1'b0;
    def_waddr = row_index(source_state);
    def_wdata = target_state;
    if (clr_active) begin
      exp_we    = 1'b1;
      exp_waddr = clr_idx;
      exp_wdata = '{valid: 1'b0, target: dfm_pkg::INIT_STATE};
      def_we    = (clr_idx[dfm_pkg::TOKEN_W-1:0] == '0);
      def_waddr = clr_idx[ADDR_W-1:dfm_pkg::TOKEN_W];
      def_wdata = dfm_pkg::INIT_STATE;
    end else if (accept && src_ok) begin
      exp_we = (fn == dfm_pkg::FUNC_WR_EXPLICIT);
      def_we = (fn == dfm_pkg::FUNC_WR_DEFAULT);
    end
  end

  assign exp_re    = accept && (fn == dfm_pkg::FUNC_STEP);
  assign exp_raddr = {row_index(state_eff), token};
  assign def_raddr = row_index(state_eff);

  dfm_ram #(
    .WIDTH (dfm_pkg::STATE_W + 1),
    .DEPTH (EXP_DEPTH)
  ) u_exp_ram (
    .clk   (clk),
    .we    (exp_we),
    .waddr (exp_waddr),
    .wdata (exp_wdata),
    .re    (exp_re),
    .raddr (exp_raddr),
    .rdata (exp_rdata)
  );

  dfm_ram #(
    .WIDTH (dfm_pkg::STATE_W),
    .DEPTH (ROWS)
  ) u_def_ram (
    .clk   (clk),
    .we    (def_we),
    .waddr (def_waddr),
    .wdata (def_wdata),
    .re    (exp_re),
    .raddr (def_raddr),
    .rdata (def_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_idx    <= '0;
      cur_state  <= dfm_pkg::INIT_STATE;
      pend       <= 1'b0;
      p_valid    <= 1'b0;
    end else begin
      if (clr_active) begin
        if (clr_idx == CLR_LAST) begin
          clr_active <= 1'b0;
        end else begin
          clr_idx <= clr_idx + 1'b1;
        end
      end
      p_valid <= accept;
      if (accept) begin
        case (fn)
          dfm_pkg::FUNC_SET_STATE: begin
            cur_state <= source_state;
            pend      <= 1'b0;
          end
          dfm_pkg::FUNC_STEP: begin
            cur_state <= eff_ok ? state_eff : dfm_pkg::INIT_STATE;
            pend      <= eff_ok;
          end
          default: begin
            cur_state <= state_eff;
            pend      <= 1'b0;
          end
        endcase
      end else if (pend) begin
        cur_state <= state_eff;
        pend      <= 1'b0;
      end
    end
  end

  dfm_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (p_valid),
    .push_state (state_eff),
    .count      (q_count),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .state_now  (state_now),
    .accepted   (accepted),
    .rejected   (rejected)
  );

`ifndef SYNTH
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !req_ready)
    else $error("request taken during table clear");

  a_pend_from_step: assert property (@(posedge clk) disable iff (rst)
    pend |-> $past(accept && (fn == dfm_pkg::FUNC_STEP)))
    else $error("table lookup pending without a token step");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (q_count < dfm_pkg::OUTQ_CNT_W'(dfm_pkg::OUTQ_DEPTH)))
    else $error("result queue overflow");

  a_set_state: assert property (@(posedge clk) disable iff (rst)
    (accept && (fn == dfm_pkg::FUNC_SET_STATE)) |=> (state_eff == $past(source_state)))
    else $error("set state result mismatch");
`endif

endmodule
`default_nettype wire

>>> tb/sv/table_driven_dfa_matcher_test.sv
`default_nettype none
module table_driven_dfa_matcher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STATE_COUNT = 64;
  localparam int ROWS        = STATE_COUNT + 2;
  localparam int RAND_ITEMS  = 2000;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD   = 400;

  typedef struct {
    dfm_pkg::func_t  f;
    dfm_pkg::state_t src;
    dfm_pkg::token_t tok;
    dfm_pkg::state_t tgt;
    bit              drain;
  } dfa_req_t;

  typedef struct {
    dfm_pkg::state_t st;
    logic            acc;
    logic            rej;
  } dfa_rsp_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            req_valid = 1'b0;
  logic            req_ready;
  logic [1:0]      func = 2'd0;
  dfm_pkg::state_t source_state = dfm_pkg::INIT_STATE;
  dfm_pkg::token_t token = '0;
  dfm_pkg::state_t target_state = dfm_pkg::INIT_STATE;
  logic            rsp_valid;
  logic            rsp_ready = 1'b0;
  dfm_pkg::state_t state_now;
  logic            accepted;
  logic            rejected;

  dfa_req_t pending[$];
  dfa_rsp_t rsp_expected[$];
  dfa_req_t cur_req;

  bit              has_entry [ROWS][dfm_pkg::TOKENS];
  dfm_pkg::state_t entry_tgt [ROWS][dfm_pkg::TOKENS];
  dfm_pkg::state_t dflt_tgt [ROWS];
  dfm_pkg::state_t dfa_state = dfm_pkg::INIT_STATE;

  int n_total;
  int n_taken;
  int n_steps;
  int n_checked;
  int n_acc;
  int n_rej;
  int n_miss;
  int n_cycles;
  int n_seen;
  int send_gap;
  int hold_left;
  bit long_hold_done;

  table_driven_dfa_matcher #(
    .STATE_COUNT(STATE_COUNT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .func(func),
    .source_state(source_state),
    .token(token),
    .target_state(target_state),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .state_now(state_now),
    .accepted(accepted),
    .rejected(rejected)
  );

  always #10 clk = ~clk;

  function automatic dfa_rsp_t dfa_advance(dfa_req_t r);
    int row;
    dfa_rsp_t o;
    if (r.f == dfm_pkg::FUNC_STEP) row = int'(dfa_state) + 2;
    else row = int'(r.src) + 2;
    if (row < 0 || row >= ROWS) row = -1;
    case (r.f)
      dfm_pkg::FUNC_WR_EXPLICIT: begin
        if (row >= 0) begin
          has_entry[row][r.tok] = 1'b1;
          entry_tgt[row][r.tok] = r.tgt;
        end
      end
      dfm_pkg::FUNC_WR_DEFAULT: begin
        if (row >= 0) dflt_tgt[row] = r.tgt;
      end
      dfm_pkg::FUNC_SET_STATE: begin
        dfa_state = r.src;
      end
      default: begin
        n_steps++;
        if (row < 0) dfa_state = dfm_pkg::INIT_STATE;
        else if (has_entry[row][r.tok]) dfa_state = entry_tgt[row][r.tok];
        else dfa_state = dflt_tgt[row];
      end
    endcase
    o.st  = dfa_state;
    o.acc = (dfa_state == dfm_pkg::HIT_STATE);
    o.rej = (dfa_state == dfm_pkg::DEAD_STATE);
    return o;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 90) return $urandom_range(1, 3);
    if (k < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_state();
    int k;
    k = $urandom_range(0, 99);
    if (k < 75) return int'($urandom_range(0, 9)) - 2;
    if (k < 90) return $urandom_range(0, STATE_COUNT - 1);
    return int'($urandom_range(0, 127)) - 64;
  endfunction

  function automatic int pick_target();
    int k;
    k = $urandom_range(0, 99);
    if (k < 15) return -1;
    if (k < 25) return -2;
    return pick_state();
  endfunction

  function automatic int any_state();
    return int'($urandom_range(0, 127)) - 64;
  endfunction

  task automatic add_req(dfm_pkg::func_t f, int src, int tok, int tgt, bit drain = 1'b0);
    dfa_req_t r;
    r.f     = f;
    r.src   = dfm_pkg::state_t'(src);
    r.tok   = dfm_pkg::token_t'(tok);
    r.tgt   = dfm_pkg::state_t'(tgt);
    r.drain = drain;
    pending.push_back(r);
  endtask

  task automatic flag_miss(string msg);
    n_miss++;
    if (n_miss <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // request driver
  always @(posedge clk) begin : send
    logic take;
    logic nv;
    if (rst) begin
      req_valid    <= 1'b0;
      func         <= dfm_pkg::FUNC_STEP;
      source_state <= dfm_pkg::INIT_STATE;
      token        <= '0;
      target_state <= dfm_pkg::INIT_STATE;
      send_gap = 0;
    end else begin
      take = req_valid && req_ready;
      if (take) begin
        rsp_expected.push_back(dfa_advance(cur_req));
        n_taken++;
        send_gap = (n_taken >= 800 && n_taken < 1100) ? 0 : gap_len();
      end
      if (req_valid && !take) begin
        nv = 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        nv = 1'b0;
      end else if (pending.size() > 0 && !(pending[0].drain && rsp_expected.size() > 0)) begin
        cur_req = pending.pop_front();
        func         <= cur_req.f;
        source_state <= cur_req.src;
        token        <= cur_req.tok;
        target_state <= cur_req.tgt;
        nv = 1'b1;
      end else begin
        nv = 1'b0;
      end
      req_valid <= nv;
    end
  end

  // result checker
  always @(posedge clk) begin : check
    dfa_rsp_t w;
    if (!rst && rsp_valid && rsp_ready) begin
      if (rsp_expected.size() == 0) begin
        flag_miss($sformatf("unexpected result: state_now %0d accepted %0b rejected %0b",
                            state_now, accepted, rejected));
      end else begin
        w = rsp_expected.pop_front();
        n_checked++;
        if (w.acc) n_acc++;
        if (w.rej) n_rej++;
        if (state_now !== w.st)
          flag_miss($sformatf("state_now: expected %0d, got %0d", w.st, state_now));
        if (accepted !== w.acc)
          flag_miss($sformatf("accepted: expected %0b, got %0b", w.acc, accepted));
        if (rejected !== w.rej)
          flag_miss($sformatf("rejected: expected %0b, got %0b", w.rej, rejected));
      end
    end
  end

  // result ready pacing
  always @(posedge clk) begin : pace
    if (rst) begin
      rsp_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp_valid && rsp_ready) n_seen++;
      if (n_seen >= 300 && !long_hold_done) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (n_seen >= 1200 && n_seen < 1500) begin
        rsp_ready <= 1'b1;
      end else begin
        hold_left = gap_len();
        rsp_ready <= (hold_left == 0);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("table_driven_dfa_matcher_test: FAIL");
      $finish;
    end
  end

  initial begin : stim
    int n_seq;
    int tok_base;
    for (int i = 0; i < ROWS; i++) dflt_tgt[i] = dfm_pkg::INIT_STATE;

    add_req(dfm_pkg::FUNC_STEP, 0, 0, 0);
    add_req(dfm_pkg::FUNC_WR_DEFAULT, 0, 0, 5);
    add_req(dfm_pkg::FUNC_WR_EXPLICIT, 0, 255, 1);
    add_req(dfm_pkg::FUNC_STEP, 0, 255, 0);
    add_req(dfm_pkg::FUNC_WR_DEFAULT, 1, 0, -1);
    add_req(dfm_pkg::FUNC_STEP, 0, 7, 0);
    add_req(dfm_pkg::FUNC_WR_EXPLICIT, -1, 0, -2);
    add_req(dfm_pkg::FUNC_STEP, 0, 0, 0);
    add_req(dfm_pkg::FUNC_STEP, 0, 1, 0);
    add_req(dfm_pkg::FUNC_STEP, 0, 128, 0);
    add_req(dfm_pkg::FUNC_WR_EXPLICIT, 0, 128, 63);
    add_req(dfm_pkg::FUNC_SET_STATE, 0, 0, 0);
    add_req(dfm_pkg::FUNC_STEP, 0, 128, 0);
    add_req(dfm_pkg::FUNC_WR_DEFAULT, 63, 0, -64);
    add_req(dfm_pkg::FUNC_STEP, 0, 3, 0);
    add_req(dfm_pkg::FUNC_STEP, 0, 3, 0);
    add_req(dfm_pkg::FUNC_WR_EXPLICIT, -3, 0, 9);
    add_req(dfm_pkg::FUNC_WR_DEFAULT, -64, 0, 9);
    add_req(dfm_pkg::FUNC_SET_STATE, -3, 0, 0);
    add_req(dfm_pkg::FUNC_STEP, 0, 0, 0);
    add_req(dfm_pkg::FUNC_WR_EXPLICIT, -2, 255, -3);
    add_req(dfm_pkg::FUNC_SET_STATE, -2, 0, 0);
    add_req(dfm_pkg::FUNC_STEP, 0, 255, 0);
    add_req(dfm_pkg::FUNC_STEP, 0, 255, 0);
    add_req(dfm_pkg::FUNC_SET_STATE, 0, 0, 0, 1'b1);

    n_seq = 0;
    while (pending.size() < RAND_ITEMS + 25) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(3, 10))
          add_req(dfm_pkg::func_t'($urandom_range(0, 3)), any_state(),
                  $urandom_range(0, 255), any_state());
      end else begin
        tok_base = $urandom_range(0, 255);
        add_req(dfm_pkg::FUNC_WR_DEFAULT, pick_state(), $urandom_range(0, 255),
                pick_target(), n_seq % 8 == 0);
        repeat ($urandom_range(0, 3))
          add_req(dfm_pkg::FUNC_WR_DEFAULT, pick_state(), $urandom_range(0, 255),
                  pick_target());
        repeat ($urandom_range(1, 8))
          add_req(dfm_pkg::FUNC_WR_EXPLICIT, pick_state(), tok_base + $urandom_range(0, 3),
                  pick_target());
        add_req(dfm_pkg::FUNC_SET_STATE, pick_state(), $urandom_range(0, 255), any_state());
        repeat ($urandom_range(4, 30))
          add_req(dfm_pkg::FUNC_STEP, any_state(),
                  ($urandom_range(0, 3) != 0) ? tok_base + $urandom_range(0, 3)
                                              : $urandom_range(0, 255),
                  any_state());
      end
      n_seq++;
    end
    n_total = pending.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (n_taken < n_total) @(posedge clk);
    while (rsp_expected.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d requests (%0d token steps), checked %0d results, %0d accepting, %0d %s",
             n_taken, n_steps, n_checked, n_acc, n_rej, "rejecting.");
    $display("Result side held off %0d cycles once, input drained several times; %0d mismatches.",
             LONG_HOLD, n_miss);
    if (n_miss == 0) begin
      $display("table_driven_dfa_matcher_test: PASS");
    end else begin
      $display("table_driven_dfa_matcher_test: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
